// ----- rtl/rfg_pkg.sv -----
`timescale 1ns / 1ps
package rfg_pkg;

  localparam int SizeW  = 13;
  localparam int CoordW = 9;
  localparam int CharW  = 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_ROWS_USED  = 2'd0;
  localparam logic [1:0] REG_COLS_USED  = 2'd1;
  localparam logic [1:0] REG_BLANK_CHAR = 2'd2;

  localparam logic [CoordW-1:0] ROWS_USED_RESET = 9'd256;
  localparam logic [CoordW-1:0] COLS_USED_RESET = 9'd256;
  localparam logic [CharW-1:0]  BLANK_RESET     = 8'd46;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CoordW-1:0] row_a;
    logic [CoordW-1:0] col_a;
    logic [CoordW-1:0] row_b;
    logic [CoordW-1:0] col_b;
    logic [CharW-1:0]  fill_char;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] cell_char;
    logic             is_read;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_t;

  // Active size: a zero register counts as one, and the size never exceeds the grid.
  function automatic logic [SizeW-1:0] eff_size(input logic [CoordW-1:0] reg_val,
                                                input logic [SizeW-1:0] limit);
    logic [SizeW-1:0] v;
    v = SizeW'(reg_val);
    if (v == '0) begin
      v = SizeW'(1);
    end else if (v > limit) begin
      v = limit;
    end
    return v;
  endfunction

  // Clamps a 1-based coordinate into [1, size] and returns it 0-based.
  function automatic logic [SizeW-1:0] clip0(input logic [CoordW-1:0] coord,
                                             input logic [SizeW-1:0] size);
    logic [SizeW-1:0] v;
    v = SizeW'(coord);
    if (v == '0) begin
      v = SizeW'(1);
    end
    if (v > size) begin
      v = size;
    end
    return v - SizeW'(1);
  endfunction

endpackage

// ----- rtl/rectangle_fill_grid.sv -----
`timescale 1ns / 1ps
// A read passes through ST_READ, which registers the cell, and ST_DONE, which loads the output
// register; a fill sweeps its clipped area, a clear the active rows by columns, before ST_DONE.
// Throughput: one item at a time, one cell written per cycle through the single
// memory write port, so the fill sweep sets the rate.
// Reset: synchronous; afterwards a sweep over all MAX_ROWS * MAX_COLS cells writes the
// reset blank code to every cell while input is held off; configuration is taken meanwhile.
module rectangle_fill_grid #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rfg_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rfg_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data
);
  import rfg_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CharW-1:0] mem [DEPTH];

  state_t state, state_next;

  logic [CoordW-1:0] rows_used;
  logic [CoordW-1:0] cols_used;
  logic [CharW-1:0]  blank_char;

  logic [RW-1:0] cur_row, row_hi;
  logic [CW-1:0] cur_col, col_lo, col_hi;
  logic [CharW-1:0] wchar;
  logic is_rd;
  logic [CharW-1:0] rd_data;
  logic [AW-1:0] addr;
  logic last_col, last_row;
  logic mem_we, res_load;

  logic [SizeW-1:0] nr, nc;
  logic [RW-1:0] ra, rb;
  logic [CW-1:0] ca, cb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used  <= ROWS_USED_RESET;
      cols_used  <= COLS_USED_RESET;
      blank_char <= BLANK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS_USED:  rows_used  <= cfg_data;
        REG_COLS_USED:  cols_used  <= cfg_data;
        REG_BLANK_CHAR: blank_char <= cfg_data[CharW-1:0];
        default: ;
      endcase
    end
  end

  assign nr = eff_size(rows_used, SizeW'(MAX_ROWS));
  assign nc = eff_size(cols_used, SizeW'(MAX_COLS));
  assign ra = RW'(clip0(in_data.row_a, nr));
  assign rb = RW'(clip0(in_data.row_b, nr));
  assign ca = CW'(clip0(in_data.col_a, nc));
  assign cb = CW'(clip0(in_data.col_b, nc));

  assign addr     = AW'(AW'(cur_row) * AW'(MAX_COLS) + AW'(cur_col));
  assign last_col = (cur_col == col_hi);
  assign last_row = (cur_row == row_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_INIT: begin
        mem_we = 1'b1;
        if (last_col && last_row) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.operation)
            OP_CLEAR, OP_FILL: state_next = ST_FILL;
            OP_READ:           state_next = ST_READ;
            default:           state_next = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (last_col && last_row) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid || out_ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      col_lo  <= '0;
      row_hi  <= RW'(MAX_ROWS - 1);
      col_hi  <= CW'(MAX_COLS - 1);
      wchar   <= BLANK_RESET;
      is_rd   <= 1'b0;
    end else if (in_valid && in_ready) begin
      is_rd <= (in_data.operation == OP_READ);
      unique case (in_data.operation)
        OP_CLEAR: begin
          col_lo  <= '0;
          row_hi  <= RW'(nr - SizeW'(1));
          col_hi  <= CW'(nc - SizeW'(1));
          cur_row <= '0;
          cur_col <= '0;
          wchar   <= blank_char;
        end
        OP_FILL: begin
          row_hi  <= (ra < rb) ? rb : ra;
          col_lo  <= (ca < cb) ? ca : cb;
          col_hi  <= (ca < cb) ? cb : ca;
          cur_row <= (ra < rb) ? ra : rb;
          cur_col <= (ca < cb) ? ca : cb;
          wchar   <= in_data.fill_char;
        end
        OP_READ: begin
          cur_row <= ra;
          cur_col <= ca;
        end
        default: ;
      endcase
    end else if (mem_we) begin
      if (last_col) begin
        cur_col <= col_lo;
        if (!last_row) begin
          cur_row <= cur_row + RW'(1);
        end
      end else begin
        cur_col <= cur_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wchar;
    end
    if (state == ST_READ) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data.cell_char <= is_rd ? rd_data : '0;
      out_data.is_read   <= is_rd;
    end
  end

endmodule

// ----- tb/rectangle_fill_grid_tb.sv -----
`timescale 1ns / 1ps
module rectangle_fill_grid_tb;
  import rfg_pkg::*;

  localparam int GRID_ROWS = 256;
  localparam int GRID_COLS = 256;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [CoordW-1:0] cfg_data;

  // Shadow copy of the grid and of the three registers.
  logic [CharW-1:0]  grid_model [GRID_ROWS*GRID_COLS];
  logic [CoordW-1:0] rows_setting = ROWS_USED_RESET;
  logic [CoordW-1:0] cols_setting = COLS_USED_RESET;
  logic [CharW-1:0]  blank_setting = BLANK_RESET;

  out_item_t awaited_replies [$];
  out_item_t want;
  int mismatches = 0;
  int replies_seen = 0;
  int cfg_writes = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int hold_cycles = 0;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;

  rectangle_fill_grid #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #60_000_000;
    $display("rectangle_fill_grid_tb failed");
    $finish;
  end

  function automatic int active_extent(logic [CoordW-1:0] reg_val, int limit);
    int v;
    v = int'(reg_val);
    if (v < 1) v = 1;
    if (v > limit) v = limit;
    return v;
  endfunction

  // Coordinates are 1-based on the port; the shadow grid is indexed from zero.
  function automatic int clip_coord(logic [CoordW-1:0] coord, int extent);
    int v;
    v = int'(coord);
    if (v < 1) v = 1;
    if (v > extent) v = extent;
    return v - 1;
  endfunction

  function automatic void paint_rect(int r0, int r1, int c0, int c1, logic [CharW-1:0] code);
    for (int r = r0; r <= r1; r++) begin
      for (int c = c0; c <= c1; c++) begin
        grid_model[r*GRID_COLS + c] = code;
      end
    end
  endfunction

  function automatic out_item_t apply_grid_op(in_item_t item);
    int nr, nc, ra, rb, ca, cb;
    out_item_t res;
    nr = active_extent(rows_setting, GRID_ROWS);
    nc = active_extent(cols_setting, GRID_COLS);
    res = '0;
    case (item.operation)
      OP_CLEAR: begin
        paint_rect(0, nr - 1, 0, nc - 1, blank_setting);
      end
      OP_FILL: begin
        ra = clip_coord(item.row_a, nr);
        rb = clip_coord(item.row_b, nr);
        ca = clip_coord(item.col_a, nc);
        cb = clip_coord(item.col_b, nc);
        paint_rect((ra < rb) ? ra : rb, (ra < rb) ? rb : ra,
                   (ca < cb) ? ca : cb, (ca < cb) ? cb : ca, item.fill_char);
      end
      OP_READ: begin
        ra = clip_coord(item.row_a, nr);
        ca = clip_coord(item.col_a, nc);
        res.cell_char = grid_model[ra*GRID_COLS + ca];
        res.is_read = 1'b1;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, int ra, int ca, int rb, int cb, int ch);
    in_item_t item;
    item.operation = op;
    item.row_a = CoordW'(ra);
    item.col_a = CoordW'(ca);
    item.row_b = CoordW'(rb);
    item.col_b = CoordW'(cb);
    item.fill_char = CharW'(ch);
    return item;
  endfunction

  // Mostly inside the active area, sometimes anywhere in the field's range.
  function automatic logic [CoordW-1:0] pick_coord(int extent);
    if ($urandom_range(0, 4) == 0) return CoordW'($urandom_range(0, 511));
    return CoordW'($urandom_range(1, extent));
  endfunction

  function automatic in_item_t random_item(int nr, int nc, bit near_rects);
    in_item_t item;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) item.operation = OP_READ;
    else if (pick < 85) item.operation = OP_FILL;
    else if (pick < 93) item.operation = near_rects ? OP_FILL : OP_CLEAR;
    else item.operation = OP_NONE;
    item.fill_char = CharW'($urandom);
    if (near_rects) begin
      // Small rectangles around a random point keep the sweep short on the full grid.
      item.row_a = CoordW'($urandom_range(6, 505));
      item.col_a = CoordW'($urandom_range(6, 505));
      item.row_b = item.row_a + CoordW'($urandom_range(0, 12)) - CoordW'(6);
      item.col_b = item.col_a + CoordW'($urandom_range(0, 12)) - CoordW'(6);
    end else begin
      item.row_a = pick_coord(nr);
      item.col_a = pick_coord(nc);
      item.row_b = pick_coord(nr);
      item.col_b = pick_coord(nc);
    end
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    gap = sender_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    awaited_replies.push_back(apply_grid_op(item));
    op_count[item.operation]++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CoordW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROWS_USED: rows_setting = value;
      REG_COLS_USED: cols_setting = value;
      REG_BLANK_CHAR: blank_setting = value[CharW-1:0];
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic set_geometry(input logic [CoordW-1:0] rows, input logic [CoordW-1:0] cols,
                              input logic [CharW-1:0] blank);
    write_reg(REG_ROWS_USED, rows);
    write_reg(REG_COLS_USED, cols);
    write_reg(REG_BLANK_CHAR, {1'b0, blank});
  endtask

  // The first transfer also waits out the clearing sweep that follows reset.
  task automatic test_reset_contents();
    send_item(make_item(OP_READ, 1, 1, 0, 0, 0));
    send_item(make_item(OP_READ, 256, 256, 0, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 511, 511, 255));
    send_item(make_item(OP_READ, 511, 511, 0, 0, 0));
    send_item(make_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom));
    wait_idle();
  endtask

  task automatic test_fill_corners();
    send_item(make_item(OP_FILL, 0, 0, 511, 511, 8'h41));
    send_item(make_item(OP_READ, 256, 256, 0, 0, 0));
    // Corners given largest first.
    send_item(make_item(OP_FILL, 9, 7, 3, 2, 8'h00));
    send_item(make_item(OP_READ, 3, 2, 0, 0, 0));
    send_item(make_item(OP_READ, 9, 7, 0, 0, 0));
    send_item(make_item(OP_READ, 10, 7, 0, 0, 0));
    send_item(make_item(OP_FILL, 256, 1, 256, 1, 8'hFF));
    send_item(make_item(OP_READ, 256, 1, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_active_size();
    set_geometry(9'd4, 9'd3, 8'hFF);
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 4, 3, 0, 0, 0));
    send_item(make_item(OP_READ, 511, 511, 0, 0, 0));
    wait_idle();
    // Cells outside the old active area must still hold the earlier fill.
    set_geometry(9'd256, 9'd256, 8'hFF);
    send_item(make_item(OP_READ, 5, 4, 0, 0, 0));
    send_item(make_item(OP_READ, 4, 3, 0, 0, 0));
    wait_idle();
    // A zero size counts as one row and one column.
    set_geometry(9'd0, 9'd0, 8'h00);
    send_item(make_item(OP_FILL, 511, 511, 300, 300, 8'h5A));
    send_item(make_item(OP_READ, 7, 7, 0, 0, 0));
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 1, 1, 0, 0, 0));
    wait_idle();
    write_reg(REG_UNUSED, 9'h1FF);
    set_geometry(9'd511, 9'd511, BLANK_RESET);
    send_item(make_item(OP_READ, 2, 2, 0, 0, 0));
    send_item(make_item(OP_READ, 1, 1, 0, 0, 0));
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 256, 256, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_backpressure();
    int nr, nc;
    set_geometry(9'd8, 9'd8, 8'h2A);
    nr = active_extent(rows_setting, GRID_ROWS);
    nc = active_extent(cols_setting, GRID_COLS);
    sender_idle = 1'b0;
    hold_cycles = 300;
    repeat (20) send_item(random_item(nr, nc, 1'b0));
    wait_idle();
    sender_idle = 1'b1;
  endtask

  task automatic test_random_traffic(input logic [CoordW-1:0] rows, input logic [CoordW-1:0] cols,
                                     input logic [CharW-1:0] blank, input int count,
                                     input bit idle_in, input bit idle_out, input bit near_rects);
    int nr, nc;
    set_geometry(rows, cols, blank);
    nr = active_extent(rows_setting, GRID_ROWS);
    nc = active_extent(cols_setting, GRID_COLS);
    sender_idle = idle_in;
    receiver_idle = idle_out;
    for (int i = 0; i < count; i++) begin
      send_item(random_item(nr, nc, near_rects));
      if ($urandom_range(0, 39) == 0) wait_idle();
    end
    wait_idle();
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
  endtask

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = receiver_idle ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      replies_seen++;
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: cell_char %0h, is_read %0b", out_data.cell_char,
               out_data.is_read);
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_data.cell_char !== want.cell_char) begin
          $error("cell_char: expected %0h, got %0h", want.cell_char, out_data.cell_char);
          mismatches++;
        end
        if (out_data.is_read !== want.is_read) begin
          $error("is_read: expected %0b, got %0b", want.is_read, out_data.is_read);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROWS_USED;
    cfg_data <= '0;
    for (int i = 0; i < GRID_ROWS*GRID_COLS; i++) begin
      grid_model[i] = BLANK_RESET;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_contents();
    test_fill_corners();
    test_active_size();
    test_backpressure();
    test_random_traffic(9'd8, 9'd8, 8'h2E, 100, 1'b1, 1'b1, 1'b0);
    test_random_traffic(CoordW'($urandom_range(1, 16)), CoordW'($urandom_range(1, 16)),
                        CharW'($urandom), 100, 1'b0, 1'b0, 1'b0);
    test_random_traffic(9'd511, 9'd2, CharW'($urandom), 100, 1'b1, 1'b0, 1'b0);
    test_random_traffic(9'd1, 9'd16, 8'h00, 100, 1'b0, 1'b1, 1'b0);
    test_random_traffic(9'd0, CoordW'($urandom_range(0, 16)), 8'hFF, 100, 1'b1, 1'b1, 1'b0);
    test_random_traffic(9'd256, 9'd256, CharW'($urandom), 100, 1'b1, 1'b1, 1'b1);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d results: %0d reads, %0d fills, %0d clears, %0d unused-code items.",
             replies_seen, op_count[OP_READ], op_count[OP_FILL], op_count[OP_CLEAR],
             op_count[OP_NONE]);
    $display("%0d register writes; grids from 1x1 to 256x256, with output hold-off and pauses.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("rectangle_fill_grid_tb passed");
    end else begin
      $display("rectangle_fill_grid_tb failed");
    end
    $finish;
  end

endmodule
